// ===== design/bfl_pkg.sv =====
// ---------------------------------------------------------------------------
// bfl_pkg: shared definitions for the path command flattener
// Widths, opcodes, sample token types and the Bernstein weight function.
// ---------------------------------------------------------------------------
`default_nettype none

package bfl_pkg;

  localparam int CURVE_STEPS = 8;
  localparam int COORD_W     = 20;
  localparam int OUT_W       = 16;
  localparam int OP_W        = 3;
  localparam int K_W         = $clog2(CURVE_STEPS + 1);
  localparam int WGT_W       = $clog2(CURVE_STEPS * CURVE_STEPS * CURVE_STEPS + 1);
  localparam int PROD_W      = COORD_W + WGT_W + 1;
  localparam int NUM_W       = PROD_W + 2;
  // samples carry S^3 weight and Q15.4 fraction
  localparam int CURVE_DIV   = CURVE_STEPS * CURVE_STEPS * CURVE_STEPS * 16;

  typedef enum logic [OP_W-1:0] {
    OP_MOVE  = 3'd0,
    OP_LINE  = 3'd1,
    OP_CURVE = 3'd2,
    OP_CLOSE = 3'd3
  } op_e;

  // one sample request: k and the four control points
  typedef struct packed {
    logic               action;
    logic               last;
    logic [K_W-1:0]     k;
    logic [COORD_W-1:0] p0_x;
    logic [COORD_W-1:0] p0_y;
    logic [COORD_W-1:0] p1_x;
    logic [COORD_W-1:0] p1_y;
    logic [COORD_W-1:0] p2_x;
    logic [COORD_W-1:0] p2_y;
    logic [COORD_W-1:0] p3_x;
    logic [COORD_W-1:0] p3_y;
  } bfl_tok_t;

  // weighted terms of one sample
  typedef struct packed {
    logic                   action;
    logic                   last;
    logic [3:0][PROD_W-1:0] prod_x;
    logic [3:0][PROD_W-1:0] prod_y;
  } bfl_prod_t;

  // unnormalised Bernstein weight of control point idx at step k
  function automatic logic [WGT_W-1:0] bern_w(input logic [K_W-1:0] k,
                                               input logic [1:0]     idx);
    int kk;
    int uu;
    int w;
    kk = int'(k);
    uu = CURVE_STEPS - kk;
    unique case (idx)
      2'd0: w = uu * uu * uu;
      2'd1: w = 3 * uu * uu * kk;
      2'd2: w = 3 * uu * kk * kk;
      2'd3: w = kk * kk * kk;
    endcase
    return WGT_W'(w);
  endfunction

endpackage

`default_nettype wire

// ===== design/bfl_cmd.sv =====
// ---------------------------------------------------------------------------
// bfl_cmd: command register and sample sequencer
// Tracks the pen point and halt flag, holds one command and issues its samples.
// ---------------------------------------------------------------------------
`default_nettype none

module bfl_cmd import bfl_pkg::*; (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [OP_W-1:0]           op_i,
  input  wire logic signed [COORD_W-1:0] ctrl1_x_i,
  input  wire logic signed [COORD_W-1:0] ctrl1_y_i,
  input  wire logic signed [COORD_W-1:0] ctrl2_x_i,
  input  wire logic signed [COORD_W-1:0] ctrl2_y_i,
  input  wire logic signed [COORD_W-1:0] end_x_i,
  input  wire logic signed [COORD_W-1:0] end_y_i,
  input  wire logic                      final_command_i,
  output logic                           tok_valid_o,
  output bfl_tok_t                       tok_o,
  input  wire logic                      tok_ready_i
);

  localparam logic [K_W-1:0] KLast = K_W'(CURVE_STEPS);

  logic [COORD_W-1:0] pen_x_q, pen_y_q;
  logic               halted_q;
  logic               cmd_valid_q;
  logic [K_W-1:0]     k_q;
  bfl_tok_t           cmd_q;

  logic tok_fire, tok_done, acc;
  logic is_move, is_line, is_curve, is_close, is_draw, emit;

  assign tok_fire   = cmd_valid_q & tok_ready_i;
  assign tok_done   = tok_fire & (k_q == KLast);
  assign in_ready_o = ~cmd_valid_q | tok_done;
  assign acc        = in_valid_i & in_ready_o;

  assign is_move  = (op_i == OP_MOVE);
  assign is_line  = (op_i == OP_LINE);
  assign is_curve = (op_i == OP_CURVE);
  assign is_close = (op_i == OP_CLOSE);
  assign is_draw  = is_move | is_line | is_curve;
  assign emit     = acc & ~halted_q & is_draw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_x_q     <= '0;
      pen_y_q     <= '0;
      halted_q    <= 1'b0;
      cmd_valid_q <= 1'b0;
      k_q         <= '0;
    end else begin
      if (acc) begin
        if (final_command_i) begin
          pen_x_q  <= '0;
          pen_y_q  <= '0;
          halted_q <= 1'b0;
        end else if (!halted_q) begin
          if (is_draw) begin
            pen_x_q <= end_x_i;
            pen_y_q <= end_y_i;
          end else if (!is_close) begin
            halted_q <= 1'b1;
          end
        end
      end
      // move and line reuse the last curve step, whose weights pick the end point
      if (emit) begin
        cmd_valid_q <= 1'b1;
        k_q         <= is_curve ? K_W'(1) : KLast;
      end else if (tok_done) begin
        cmd_valid_q <= 1'b0;
      end else if (tok_fire) begin
        k_q <= k_q + K_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      cmd_q.action <= is_curve | is_line;
      cmd_q.last   <= 1'b0;
      cmd_q.k      <= '0;
      cmd_q.p0_x   <= pen_x_q;
      cmd_q.p0_y   <= pen_y_q;
      cmd_q.p1_x   <= ctrl1_x_i;
      cmd_q.p1_y   <= ctrl1_y_i;
      cmd_q.p2_x   <= ctrl2_x_i;
      cmd_q.p2_y   <= ctrl2_y_i;
      cmd_q.p3_x   <= end_x_i;
      cmd_q.p3_y   <= end_y_i;
    end
  end

  always_comb begin
    tok_o      = cmd_q;
    tok_o.k    = k_q;
    tok_o.last = (k_q == KLast);
  end

  assign tok_valid_o = cmd_valid_q;

endmodule

`default_nettype wire

// ===== design/bfl_mul.sv =====
// ---------------------------------------------------------------------------
// bfl_mul: weighted term stage
// Multiplies each control point by its Bernstein weight for the sample step.
// ---------------------------------------------------------------------------
`default_nettype none

module bfl_mul import bfl_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      tok_valid_i,
  input  wire bfl_tok_t  tok_i,
  output logic           tok_ready_o,
  output logic           prod_valid_o,
  output bfl_prod_t      prod_o,
  input  wire logic      prod_ready_i
);

  logic      valid_q;
  bfl_prod_t prod_q, prod_d;

  logic [3:0][COORD_W-1:0] pt_x, pt_y;
  logic signed [PROD_W-1:0] ax, ay, bw;

  assign pt_x = {tok_i.p3_x, tok_i.p2_x, tok_i.p1_x, tok_i.p0_x};
  assign pt_y = {tok_i.p3_y, tok_i.p2_y, tok_i.p1_y, tok_i.p0_y};

  always_comb begin
    prod_d        = '0;
    prod_d.action = tok_i.action;
    prod_d.last   = tok_i.last;
    ax = '0;
    ay = '0;
    bw = '0;
    for (int i = 0; i < 4; i++) begin
      ax = PROD_W'($signed(pt_x[i]));
      ay = PROD_W'($signed(pt_y[i]));
      bw = $signed(PROD_W'(bern_w(tok_i.k, 2'(i))));
      prod_d.prod_x[i] = ax * bw;
      prod_d.prod_y[i] = ay * bw;
    end
  end

  assign tok_ready_o = ~valid_q | prod_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (tok_ready_o) begin
      valid_q <= tok_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_valid_i && tok_ready_o) begin
      prod_q <= prod_d;
    end
  end

  assign prod_valid_o = valid_q;
  assign prod_o       = prod_q;

endmodule

`default_nettype wire

// ===== design/bfl_sum.sv =====
// ---------------------------------------------------------------------------
// bfl_sum: sample sum and result register
// Adds the weighted terms, scales to integer with truncation toward zero.
// ---------------------------------------------------------------------------
`default_nettype none

module bfl_sum import bfl_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            prod_valid_i,
  input  wire bfl_prod_t       prod_i,
  output logic                 prod_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic                 pen_action_o,
  output logic signed [OUT_W-1:0] point_x_o,
  output logic signed [OUT_W-1:0] point_y_o,
  output logic                 last_of_run_o
);

  localparam logic signed [NUM_W-1:0] CurveDiv = NUM_W'(CURVE_DIV);

  logic signed [NUM_W-1:0] num_x, num_y, quot_x, quot_y;
  logic                    valid_q;
  logic                    action_q, last_q;
  logic [OUT_W-1:0]        px_q, py_q;

  always_comb begin
    num_x = '0;
    num_y = '0;
    for (int i = 0; i < 4; i++) begin
      num_x = num_x + NUM_W'($signed(prod_i.prod_x[i]));
      num_y = num_y + NUM_W'($signed(prod_i.prod_y[i]));
    end
    // signed division by a power of two, rounds toward zero
    quot_x = num_x / CurveDiv;
    quot_y = num_y / CurveDiv;
  end

  assign prod_ready_o = ~valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (prod_ready_o) begin
      valid_q <= prod_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_valid_i && prod_ready_o) begin
      action_q <= prod_i.action;
      last_q   <= prod_i.last;
      px_q     <= quot_x[OUT_W-1:0];
      py_q     <= quot_y[OUT_W-1:0];
    end
  end

  assign out_valid_o   = valid_q;
  assign pen_action_o  = action_q;
  assign last_of_run_o = last_q;
  assign point_x_o     = $signed(px_q);
  assign point_y_o     = $signed(py_q);

endmodule

`default_nettype wire

// ===== design/path_command_bezier_flattener_unit.sv =====
// ---------------------------------------------------------------------------
// path_command_bezier_flattener_unit: path command flattener
// Turns move, line, cubic curve and close commands into pen results.
// ---------------------------------------------------------------------------
// Each accepted command is checked against the pen point and halt flag at
// the input, then sampled by a sequencer that issues one sample per cycle,
// unless the downstream stages stall it, into a weight multiply stage and a
// sum stage with the result register. A move or line gives one sample, a
// cubic curve CURVE_STEPS (8) samples, one per output point; close, unknown
// opcodes and commands of a halted path give no result. A result passes
// the command register, the weighted term register and the result register.
`default_nettype none

module path_command_bezier_flattener_unit import bfl_pkg::*; (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [OP_W-1:0]           op_i,
  input  wire logic signed [COORD_W-1:0] ctrl1_x_i,
  input  wire logic signed [COORD_W-1:0] ctrl1_y_i,
  input  wire logic signed [COORD_W-1:0] ctrl2_x_i,
  input  wire logic signed [COORD_W-1:0] ctrl2_y_i,
  input  wire logic signed [COORD_W-1:0] end_x_i,
  input  wire logic signed [COORD_W-1:0] end_y_i,
  input  wire logic                      final_command_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic                           pen_action_o,
  output logic signed [OUT_W-1:0]        point_x_o,
  output logic signed [OUT_W-1:0]        point_y_o,
  output logic                           last_of_run_o
);

  logic      tok_valid, tok_ready;
  bfl_tok_t  tok;
  logic      prod_valid, prod_ready;
  bfl_prod_t prod;

  bfl_cmd u_cmd (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .ctrl1_x_i      (ctrl1_x_i),
    .ctrl1_y_i      (ctrl1_y_i),
    .ctrl2_x_i      (ctrl2_x_i),
    .ctrl2_y_i      (ctrl2_y_i),
    .end_x_i        (end_x_i),
    .end_y_i        (end_y_i),
    .final_command_i(final_command_i),
    .tok_valid_o    (tok_valid),
    .tok_o          (tok),
    .tok_ready_i    (tok_ready)
  );

  bfl_mul u_mul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (tok_valid),
    .tok_i       (tok),
    .tok_ready_o (tok_ready),
    .prod_valid_o(prod_valid),
    .prod_o      (prod),
    .prod_ready_i(prod_ready)
  );

  bfl_sum u_sum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .prod_valid_i (prod_valid),
    .prod_i       (prod),
    .prod_ready_o (prod_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pen_action_o (pen_action_o),
    .point_x_o    (point_x_o),
    .point_y_o    (point_y_o),
    .last_of_run_o(last_of_run_o)
  );

endmodule

`default_nettype wire

// ===== design/bfl_checker.sv =====
// ---------------------------------------------------------------------------
// bfl_checker: port level checks for the path command flattener
// Watches the result channel of the top level over time.
// ---------------------------------------------------------------------------
`default_nettype none

module bfl_checker import bfl_pkg::*; (
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    out_valid_o,
  input wire logic                    out_ready_i,
  input wire logic                    pen_action_o,
  input wire logic signed [OUT_W-1:0] point_x_o,
  input wire logic signed [OUT_W-1:0] point_y_o,
  input wire logic                    last_of_run_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(point_x_o) &&
      $stable(point_y_o) && $stable(pen_action_o) && $stable(last_of_run_o))
    else $error("result changed while stalled");

  // a pen move is always the only result of its command
  a_move_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !pen_action_o |-> last_of_run_o)
    else $error("move result not marked last");

  // only curve samples can be followed by more results of the same command
  a_run_is_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o |-> pen_action_o)
    else $error("non-final result is not a draw");

  // an unfinished curve run continues with a draw result next transfer
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_of_run_o ##1 out_valid_o |-> pen_action_o)
    else $error("curve run interrupted by a move");

endmodule

bind path_command_bezier_flattener_unit bfl_checker u_bfl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .pen_action_o (pen_action_o),
  .point_x_o    (point_x_o),
  .point_y_o    (point_y_o),
  .last_of_run_o(last_of_run_o)
);

`default_nettype wire
